// ----- rtl/sslv_pkg.sv -----
`timescale 1ns / 1ps

package sslv_pkg;

  // Item kinds
  localparam logic [1:0] OP_BUS    = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_CHAR   = 2'd2;

  // Register map
  localparam logic [7:0] REG_VERSION0 = 8'd0;
  localparam logic [7:0] REG_VERSION1 = 8'd1;
  localparam logic [7:0] REG_CONTROL  = 8'd2;
  localparam logic [7:0] REG_STATUS   = 8'd3;
  localparam logic [7:0] REG_AVG_LO   = 8'd5;
  localparam logic [7:0] REG_AVG_HI   = 8'd6;
  localparam logic [7:0] REG_CHAR_BUF = 8'd7;
  localparam logic [7:0] REG_DEV_ID   = 8'd9;
  localparam logic [7:0] NUM_REGS     = 8'd10;

  // Fixed response bytes
  localparam logic [7:0] BAD_ANSWER   = 8'h55;
  localparam logic [7:0] DEV_ID       = 8'hAA;
  localparam logic [7:0] VERSION_BYTE = 8'h04;

  // Control register start bit, status bit positions
  localparam int CTRL_START_BIT = 1;
  localparam int STAT_FAULT_BIT = 1;
  localparam int STAT_BUSY_BIT  = 2;
  localparam int STAT_READY_BIT = 3;
  localparam int STAT_CHAR_BIT  = 5;

  // Accumulator widths
  localparam int SUM_W   = 21;
  localparam int COUNT_W = 5;
  localparam int AVG_W   = 16;

  typedef struct packed {
    logic [1:0]  opcode;
    logic        frame_ok;
    logic [7:0]  reg_addr;
    logic [7:0]  write_byte;
    logic [15:0] sample_value;
    logic [7:0]  rx_char;
  } item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       term_valid;
    logic [7:0] term_char;
  } result_t;

endpackage

// ----- rtl/sslv_core.sv -----
`timescale 1ns / 1ps

module sslv_core #(
  parameter int AVG_SAMPLES = 30
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             fire,
  input  sslv_pkg::item_t  item,
  output sslv_pkg::result_t res
);

  import sslv_pkg::*;

  // Exact reciprocal for any divisor up to 2**COUNT_W over a SUM_W-bit dividend
  localparam int DIV_SHIFT = SUM_W + COUNT_W;
  localparam int RECIP_W   = DIV_SHIFT + 1;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(AVG_SAMPLES) - 64'd1) / 64'(AVG_SAMPLES));

  logic               fault_r, fault_nxt;
  logic               busy_r, busy_nxt;
  logic               ready_r, ready_nxt;
  logic               char_flag_r, char_flag_nxt;
  logic [7:0]         char_buf_r, char_buf_nxt;
  logic [SUM_W-1:0]   total_r, total_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic [COUNT_W-1:0] count_r, count_nxt;

  logic [SUM_W-1:0]         sum_add;
  logic [COUNT_W-1:0]       count_add;
  logic [SUM_W+RECIP_W-1:0] avg_prod;
  logic [AVG_W-1:0]         avg_value;
  logic [7:0]               status;
  logic                     addr_ok;

  // Average of the last completed run
  assign avg_prod  = (SUM_W+RECIP_W)'(total_r) * (SUM_W+RECIP_W)'(RECIP);
  assign avg_value = avg_prod[DIV_SHIFT +: AVG_W];

  always_comb begin
    status = '0;
    status[STAT_FAULT_BIT] = fault_r;
    status[STAT_BUSY_BIT]  = busy_r;
    status[STAT_READY_BIT] = ready_r;
    status[STAT_CHAR_BIT]  = char_flag_r;
  end

  assign addr_ok   = item.frame_ok && (item.reg_addr < NUM_REGS);
  assign sum_add   = sum_r + SUM_W'(item.sample_value);
  assign count_add = count_r + COUNT_W'(1);

  // Form the response from the current state, then the state update
  always_comb begin
    res           = '0;
    fault_nxt     = fault_r;
    busy_nxt      = busy_r;
    ready_nxt     = ready_r;
    char_flag_nxt = char_flag_r;
    char_buf_nxt  = char_buf_r;
    total_nxt     = total_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    case (item.opcode)
      OP_BUS: begin
        if (addr_ok) begin
          case (item.reg_addr)
            REG_VERSION0, REG_VERSION1: res.read_data = VERSION_BYTE;
            REG_STATUS:   res.read_data = status;
            REG_AVG_LO:   res.read_data = avg_value[7:0];
            REG_AVG_HI: begin
              res.read_data = avg_value[15:8];
              ready_nxt     = 1'b0;
            end
            REG_CHAR_BUF: res.read_data = char_buf_r;
            REG_DEV_ID:   res.read_data = DEV_ID;
            default:      res.read_data = '0;
          endcase
          if (item.reg_addr == REG_CONTROL) begin
            if (item.write_byte[CTRL_START_BIT]) begin
              busy_nxt = 1'b1;
            end
          end else if (item.reg_addr == REG_CHAR_BUF) begin
            if (item.write_byte == 8'd0) begin
              char_flag_nxt = 1'b0;
            end else begin
              res.term_valid = 1'b1;
              res.term_char  = item.write_byte;
            end
          end
        end else begin
          res.read_data = BAD_ANSWER;
        end
      end
      OP_SAMPLE: begin
        if (busy_r) begin
          if (item.sample_value == 16'd0) begin
            fault_nxt = 1'b1;
            ready_nxt = 1'b1;
          end else if (count_add == COUNT_W'(AVG_SAMPLES)) begin
            // Close the run: keep the total; the divide is done combinationally from it
            total_nxt = sum_add;
            busy_nxt  = 1'b0;
            ready_nxt = 1'b1;
            sum_nxt   = '0;
            count_nxt = '0;
          end else begin
            sum_nxt   = sum_add;
            count_nxt = count_add;
          end
        end
      end
      OP_CHAR: begin
        char_buf_nxt  = item.rx_char;
        char_flag_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  // Commit the update when the item moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_r     <= 1'b0;
      busy_r      <= 1'b0;
      ready_r     <= 1'b0;
      char_flag_r <= 1'b0;
      char_buf_r  <= '0;
      total_r     <= '0;
      sum_r       <= '0;
      count_r     <= '0;
    end else if (fire) begin
      fault_r     <= fault_nxt;
      busy_r      <= busy_nxt;
      ready_r     <= ready_nxt;
      char_flag_r <= char_flag_nxt;
      char_buf_r  <= char_buf_nxt;
      total_r     <= total_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
    end
  end

endmodule

// ----- rtl/spi_sensor_register_slave_unit.sv -----
`timescale 1ns / 1ps

// Each input passes the input register, then the output register (out_ side).
// One item per cycle while out_stall is low; the input register refills while
// a result waits in the output register, so a stall only backs up once both
// are full. Reset (rst_n low, synchronous) empties both registers and clears
// all flags, the character buffer, running sum and count, and the average.
module spi_sensor_register_slave_unit #(
  parameter int AVG_SAMPLES = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic        in_frame_ok,
  input  logic [7:0]  in_reg_addr,
  input  logic [7:0]  in_write_byte,
  input  logic [15:0] in_sample_value,
  input  logic [7:0]  in_rx_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_term_valid,
  output logic [7:0]  out_term_char
);

  import sslv_pkg::*;

  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    out_valid_r;
  result_t out_res_r;
  result_t core_res;
  logic    s1_load;
  logic    s2_load;

  // Pipeline handshake
  assign s2_load  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s2_load;
  assign s1_load  = in_valid && !in_stall;

  sslv_core #(
    .AVG_SAMPLES(AVG_SAMPLES)
  ) u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (s2_load),
    .item (s1_item_r),
    .res  (core_res)
  );

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (s2_load) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture payloads
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_item_r.opcode       <= in_opcode;
      s1_item_r.frame_ok     <= in_frame_ok;
      s1_item_r.reg_addr     <= in_reg_addr;
      s1_item_r.write_byte   <= in_write_byte;
      s1_item_r.sample_value <= in_sample_value;
      s1_item_r.rx_char      <= in_rx_char;
    end
    if (s2_load) begin
      out_res_r <= core_res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_res_r.read_data;
  assign out_term_valid = out_res_r.term_valid;
  assign out_term_char  = out_res_r.term_char;

endmodule
